/* hw/rtl/kth_one_bit_vector_search_unit_macros.svh */
// Assertion helpers used by the checker of this block.
`ifndef KTH_ONE_BIT_VECTOR_SEARCH_UNIT_MACROS_SVH
`define KTH_ONE_BIT_VECTOR_SEARCH_UNIT_MACROS_SVH

// Plain clocked property, off while reset is held.
`define KBVS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: property violated");

// A stalled transfer keeps valid high and its payload steady.
`define KBVS_STALL(name, vld, rdy, sig) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld) && !(rdy) |=> (vld) && $stable(sig)) \
    else $error("%m: stalled transfer changed");

`endif

/* hw/rtl/kbvs_pkg.sv */
`default_nettype none

package kbvs_pkg;

  localparam int IdxW = 10;
  localparam int PosW = 10;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_TOGGLE = 2'd1,
    MODE_FIND   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IdxW-1:0] bit_index;
    logic            bit_value;
    logic [IdxW-1:0] rank;
  } in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
  } out_t;

  // Finished result handed from the controller to the output register.
  typedef struct packed {
    logic push;
    out_t data;
  } res_push_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_WALK,
    ST_ROOT,
    ST_DESC,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/kth_one_bit_vector_search_unit.sv */
`default_nettype none

// K-th set bit search over a vector of SIZE bits. The vector sits in a
// one-bit RAM and a heap-ordered tree of population counts sits in a second
// RAM (node 1 is the root, node n has children 2n and 2n+1, a node over
// [lo, hi] splits at mid = lo + (hi - lo) / 2). Mode 0 writes a bit, mode 1
// toggles it, mode 2 returns the position of the (rank+1)-th set bit with
// found = 1, or found = 0 and position 0 when rank is not below the number
// of set bits. Writes, toggles, out-of-range indices and mode 3 always
// return found = 0, position = 0; each input transfer gives exactly one
// output transfer. One item is worked on at a time. A query does one count
// RAM read for the root check, then one read per level, the next read
// address following from the last read's data. A write or toggle that
// changes the bit does a leaf read, then a read-modify-write walk down the
// path, one node read per cycle with the write-back of the previous node in
// the same cycle. A write that leaves the bit as it is ends after the leaf
// read, and an ignored request ends as it is taken. After reset the block
// clears both RAMs, one address per cycle, and holds in_ready_o low until
// done. An output register lets a new item start while the last result
// waits to be taken.

module kth_one_bit_vector_search_unit #(
  parameter int SIZE = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kbvs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kbvs_pkg::out_t out_data_o
);

  logic                out_valid_q, out_valid_d;
  kbvs_pkg::out_t      out_data_q, out_data_d;
  logic                out_free;
  kbvs_pkg::res_push_t res;

  // The register may take a new result when empty or when its transfer
  // completes in this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  kbvs_ctrl #(.SIZE(SIZE)) u_kbvs_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.push) begin
      // Load the fresh result; the controller only pushes when free.
      out_valid_d = 1'b1;
      out_data_d  = res.data;
    end else if (out_ready_i) begin
      // Drop the result once its transfer completes.
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* hw/rtl/kbvs_ram.sv */
`default_nettype none

module kbvs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old entry when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/kbvs_ctrl.sv */
`default_nettype none

module kbvs_ctrl #(
  parameter int SIZE = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  kbvs_pkg::in_t         in_data_i,
  input  logic                  out_free_i,
  output kbvs_pkg::res_push_t   res_o
);

  localparam int LeafAw   = $clog2(SIZE);
  localparam int NodeAw   = LeafAw + 1;
  localparam int CntW     = $clog2(SIZE + 1);
  localparam int TgtW     = (CntW > kbvs_pkg::IdxW + 1) ? CntW : kbvs_pkg::IdxW + 1;
  localparam int CntDepth = 2 ** NodeAw;
  localparam int PosW     = kbvs_pkg::PosW;
  localparam logic [LeafAw-1:0] LastLeaf = LeafAw'(SIZE - 1);
  localparam logic [NodeAw-1:0] RootNode = NodeAw'(1);

  kbvs_pkg::state_e state_q, state_d;
  kbvs_pkg::mode_e  op_mode_q, op_mode_d;
  logic [NodeAw-1:0] clr_q, clr_d;
  logic              pend_q, pend_d;
  logic              wend_q, wend_d;
  logic [LeafAw-1:0] idx_q, idx_d;
  logic              val_q, val_d;
  logic              inc_q, inc_d;
  logic [TgtW-1:0]   tgt_q, tgt_d;
  logic [NodeAw-1:0] node_q, node_d;
  logic [LeafAw-1:0] lo_q, lo_d;
  logic [LeafAw-1:0] hi_q, hi_d;
  logic [NodeAw-1:0] pend_node_q, pend_node_d;
  kbvs_pkg::out_t    res_q, res_d;

  logic              leaf_we;
  logic [LeafAw-1:0] leaf_waddr;
  logic [0:0]        leaf_wdata;
  logic [LeafAw-1:0] leaf_raddr;
  logic [0:0]        leaf_rdata;
  logic              cnt_we;
  logic [NodeAw-1:0] cnt_waddr;
  logic [CntW-1:0]   cnt_wdata;
  logic [NodeAw-1:0] cnt_raddr;
  logic [CntW-1:0]   cnt_rdata;

  logic [LeafAw-1:0] mid;
  logic [LeafAw-1:0] nlo;
  logic [LeafAw-1:0] nhi;
  logic [NodeAw-1:0] nnode;
  logic [TgtW-1:0]   lc;
  logic              go_left;
  logic              new_bit;
  logic              in_rng;
  logic              fin;
  kbvs_pkg::out_t    fin_res;

  kbvs_ram #(.Width(1), .Depth(SIZE)) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (leaf_we),
    .waddr_i (leaf_waddr),
    .wdata_i (leaf_wdata),
    .raddr_i (leaf_raddr),
    .rdata_o (leaf_rdata)
  );

  kbvs_ram #(.Width(CntW), .Depth(CntDepth)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    state_d     = state_q;
    op_mode_d   = op_mode_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    wend_d      = wend_q;
    idx_d       = idx_q;
    val_d       = val_q;
    inc_d       = inc_q;
    tgt_d       = tgt_q;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_node_d = pend_node_q;
    res_d       = res_q;

    in_ready_o = 1'b0;
    res_o      = '0;
    fin        = 1'b0;
    fin_res    = '0;

    mid     = lo_q + ((hi_q - lo_q) >> 1);
    lc      = TgtW'(cnt_rdata);
    go_left = (tgt_q <= lc);
    nnode   = go_left ? (node_q << 1) : ((node_q << 1) | RootNode);
    nlo     = go_left ? lo_q : (mid + LeafAw'(1));
    nhi     = go_left ? mid : hi_q;
    new_bit = (op_mode_q == kbvs_pkg::MODE_WRITE) ? val_q : ~leaf_rdata[0];
    in_rng  = 32'(in_data_i.bit_index) < 32'(SIZE);

    leaf_we    = 1'b0;
    leaf_waddr = idx_q;
    leaf_wdata = new_bit;
    leaf_raddr = idx_q;
    cnt_we     = 1'b0;
    cnt_waddr  = pend_node_q;
    cnt_wdata  = inc_q ? (cnt_rdata + CntW'(1)) : (cnt_rdata - CntW'(1));
    cnt_raddr  = node_q;

    case (state_q)
      kbvs_pkg::ST_CLEAR: begin
        leaf_we    = 32'(clr_q) < 32'(SIZE);
        leaf_waddr = LeafAw'(clr_q);
        leaf_wdata = '0;
        cnt_we     = 1'b1;
        cnt_waddr  = clr_q;
        cnt_wdata  = '0;
        clr_d      = clr_q + NodeAw'(1);
        if (&clr_q) begin
          state_d = kbvs_pkg::ST_IDLE;
        end
      end
      kbvs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_mode_d = kbvs_pkg::mode_e'(in_data_i.mode);
          idx_d     = LeafAw'(in_data_i.bit_index);
          val_d     = in_data_i.bit_value;
          tgt_d     = TgtW'(in_data_i.rank) + TgtW'(1);
          node_d    = RootNode;
          lo_d      = '0;
          hi_d      = LastLeaf;
          pend_d    = 1'b0;
          wend_d    = 1'b0;
          case (kbvs_pkg::mode_e'(in_data_i.mode))
            kbvs_pkg::MODE_WRITE, kbvs_pkg::MODE_TOGGLE: begin
              if (in_rng) begin
                leaf_raddr = LeafAw'(in_data_i.bit_index);
                state_d    = kbvs_pkg::ST_LEAF;
              end else begin
                fin = 1'b1;
              end
            end
            kbvs_pkg::MODE_FIND: begin
              cnt_raddr = RootNode;
              state_d   = kbvs_pkg::ST_ROOT;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      kbvs_pkg::ST_LEAF: begin
        // Drop the operation when the bit already holds its new value.
        if (new_bit == leaf_rdata[0]) begin
          fin = 1'b1;
        end else begin
          leaf_we = 1'b1;
          inc_d   = new_bit;
          state_d = kbvs_pkg::ST_WALK;
        end
      end
      kbvs_pkg::ST_WALK: begin
        // Write back the count read last cycle while reading the next node.
        cnt_we = pend_q;
        if (wend_q) begin
          fin = 1'b1;
        end else begin
          cnt_raddr   = node_q;
          pend_d      = 1'b1;
          pend_node_d = node_q;
          if (lo_q == hi_q) begin
            wend_d = 1'b1;
          end else if (idx_q <= mid) begin
            node_d = node_q << 1;
            hi_d   = mid;
          end else begin
            node_d = (node_q << 1) | RootNode;
            lo_d   = mid + LeafAw'(1);
          end
        end
      end
      kbvs_pkg::ST_ROOT: begin
        if (tgt_q > TgtW'(cnt_rdata)) begin
          fin = 1'b1;
        end else begin
          cnt_raddr = node_q << 1;
          state_d   = kbvs_pkg::ST_DESC;
        end
      end
      kbvs_pkg::ST_DESC: begin
        node_d = nnode;
        lo_d   = nlo;
        hi_d   = nhi;
        if (!go_left) begin
          tgt_d = tgt_q - lc;
        end
        if (nlo == nhi) begin
          fin              = 1'b1;
          fin_res.found    = 1'b1;
          fin_res.position = PosW'(nlo);
        end else begin
          cnt_raddr = nnode << 1;
        end
      end
      kbvs_pkg::ST_RESP: begin
        if (out_free_i) begin
          res_o.push = 1'b1;
          res_o.data = res_q;
          state_d    = kbvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kbvs_pkg::ST_IDLE;
      end
    endcase

    // Hand the result over, or park it until the output register frees up.
    if (fin) begin
      if (out_free_i) begin
        res_o.push = 1'b1;
        res_o.data = fin_res;
        state_d    = kbvs_pkg::ST_IDLE;
      end else begin
        res_d   = fin_res;
        state_d = kbvs_pkg::ST_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kbvs_pkg::ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      wend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      wend_q  <= wend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_mode_q   <= op_mode_d;
    idx_q       <= idx_d;
    val_q       <= val_d;
    inc_q       <= inc_d;
    tgt_q       <= tgt_d;
    node_q      <= node_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    pend_node_q <= pend_node_d;
    res_q       <= res_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/kbvs_chk.sv */
`default_nettype none

`include "kth_one_bit_vector_search_unit_macros.svh"

module kbvs_chk #(
  parameter int SIZE = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  kbvs_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  kbvs_pkg::out_t out_data_i
);

  logic       in_acc;
  logic       out_acc;
  logic       sole_held;
  logic       last_find;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] last_mode_q, last_mode_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // With one item held, the result on the output belongs to the latest transfer.
  assign sole_held = (cnt_q == 2'd1);
  assign last_find = (last_mode_q == kbvs_pkg::MODE_FIND);

  // Track items taken but not yet delivered and the mode of the latest one.
  always_comb begin
    cnt_d       = cnt_q + 2'(in_acc) - 2'(out_acc);
    last_mode_d = in_acc ? in_data_i.mode : last_mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_mode_q <= '0;
    end else begin
      cnt_q       <= cnt_d;
      last_mode_q <= last_mode_d;
    end
  end

  `KBVS_STALL(a_out_hold, out_valid_i, out_ready_i, out_data_i)
  `KBVS_ASSERT(a_found_only_for_find, out_valid_i && out_data_i.found && sole_held |-> last_find)
  `KBVS_ASSERT(a_pos_in_range, out_valid_i && out_data_i.found |-> 32'(out_data_i.position) < 32'(SIZE))
  `KBVS_ASSERT(a_ready_at_most_one_held, in_ready_i |-> cnt_q <= 2'd1)
  `KBVS_ASSERT(a_no_result_without_item, out_valid_i |-> cnt_q != 2'd0)

endmodule

bind kth_one_bit_vector_search_unit kbvs_chk #(.SIZE(SIZE)) u_kbvs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
